// File: sv/germ_pkg.sv
// ----------------------------------------------------------------------------
// germ_pkg
// Types and constants shared by the gamepad edge, repeat and merge block.
// ----------------------------------------------------------------------------
package germ_pkg;

	// Pad status codes carried in the err field.
	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_NOT_READY   = 2'd1;
	localparam logic [1:0] ERR_NO_PAD      = 2'd2;
	localparam logic [1:0] ERR_XFER        = 2'd3;

	// Link device mode in which it stands in for the pad.
	localparam logic [1:0] LINK_MODE_PAD   = 2'd0;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TRIGGER_THRESHOLD    = 2'd0;
	localparam logic [1:0] CFG_REPEAT_DELAY         = 2'd1;
	localparam logic [1:0] CFG_STICK_DPAD_ENABLE    = 2'd2;
	localparam logic [1:0] CFG_STICK_DPAD_THRESHOLD = 2'd3;

	localparam logic [7:0]  TRIGGER_THRESHOLD_RESET    = 8'd100;
	localparam logic [15:0] REPEAT_DELAY_RESET         = 16'h0010;
	localparam logic [7:0]  STICK_DPAD_THRESHOLD_RESET = 8'd1;

	// Result kinds.
	localparam logic KIND_PORT   = 1'b0;
	localparam logic KIND_MERGED = 1'b1;

	// Button bits.
	localparam logic [15:0] REPEAT_MASK = 16'h1F7F;
	localparam logic [15:0] DIR_CLEAR   = 16'hFFF0;
	localparam logic [15:0] BTN_L       = 16'h0040;
	localparam logic [15:0] BTN_R       = 16'h0020;
	localparam logic [15:0] BTN_LEFT    = 16'h0001;
	localparam logic [15:0] BTN_RIGHT   = 16'h0002;
	localparam logic [15:0] BTN_DOWN    = 16'h0004;
	localparam logic [15:0] BTN_UP      = 16'h0008;

	// Stick direction bits.
	localparam logic [3:0] DIR_LEFT  = 4'h1;
	localparam logic [3:0] DIR_RIGHT = 4'h2;
	localparam logic [3:0] DIR_DOWN  = 4'h4;
	localparam logic [3:0] DIR_UP    = 4'h8;

	typedef struct packed {
		logic [1:0]        port;
		logic [1:0]        err;
		logic [15:0]       pad_buttons;
		logic [7:0]        trigger_left;
		logic [7:0]        trigger_right;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic              link_connected;
		logic [1:0]        link_mode;
		logic [15:0]       link_buttons;
	} sample_t;

	typedef struct packed {
		logic              result_kind;
		logic              last;
		logic [15:0]       buttons_held;
		logic [15:0]       buttons_pressed;
		logic [15:0]       buttons_released;
		logic [15:0]       buttons_repeat;
		logic [3:0]        stick_dirs;
		logic [3:0]        stick_dirs_new;
		logic [15:0]       link_held;
		logic [15:0]       link_pressed;
		logic signed [7:0] stick_x_out;
		logic signed [7:0] stick_y_out;
	} result_t;

	typedef struct packed {
		logic [7:0]  trigger_threshold;
		logic [15:0] repeat_delay;
		logic        stick_dpad_enable;
		logic [7:0]  stick_dpad_threshold;
	} cfg_t;

	typedef struct packed {
		logic [15:0]       buttons;
		logic [15:0]       link_buttons;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic [3:0]        dirs;
		logic [15:0]       repeat_count;
		logic [15:0]       last_pressed;
		logic [15:0]       last_released;
		logic [15:0]       last_repeat;
		logic [3:0]        last_dirs_new;
	} port_state_t;

	typedef struct packed {
		logic [15:0]       held;
		logic [15:0]       pressed;
		logic [15:0]       released;
		logic [15:0]       repeat_bits;
		logic [3:0]        dirs;
		logic [3:0]        dirs_new;
		logic [15:0]       link_held;
		logic [15:0]       link_pressed;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
	} merge_t;

endpackage

// File: sv/gamepad_edge_repeat_merge_top.sv
// Takes one sample word per cycle unless result back-pressure or a waiting
// merged word holds it off, and gives a port result for it: the sample is
// registered, processed in one pass against the per-port state flops, and the
// result word lands in an output register. The sample for the last port also
// gives a merged frame word, which waits in a second register behind the port
// word; the next sample is held off until that word has moved to the output
// register. Ports at or above NUM_PORTS are consumed without a result.
// ----------------------------------------------------------------------------
// gamepad_edge_repeat_merge_top
// Per-port button edges, autorepeat, stick directions and link buttons, with
// an OR-merged frame result (the stick keeps the largest magnitude) after the last port.
// ----------------------------------------------------------------------------
module gamepad_edge_repeat_merge_top #(
	parameter int NUM_PORTS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  germ_pkg::sample_t   sample,
	output logic                result_valid,
	input  logic                result_ready,
	output germ_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	germ_pkg::cfg_t        cfg_q;
	logic                  s1_valid_q;
	germ_pkg::sample_t     sample_s1;
	germ_pkg::port_state_t ps_q [NUM_PORTS];
	germ_pkg::merge_t      merge_q;
	logic                  out_valid_q;
	germ_pkg::result_t     out_q;
	logic                  pend_valid_q;
	germ_pkg::result_t     pend_q;

	logic                  out_free;
	logic                  fire;
	logic                  in_range;
	logic                  last_port;
	logic [IDX_W-1:0]      idx;
	germ_pkg::port_state_t ps_next;
	germ_pkg::merge_t      acc_next;
	germ_pkg::result_t     port_res;
	germ_pkg::result_t     merge_res;

	assign out_free     = !out_valid_q || result_ready;
	assign fire         = s1_valid_q && !pend_valid_q && out_free;
	assign sample_ready = !s1_valid_q || fire;
	assign in_range     = (32'(sample_s1.port) < NUM_PORTS);
	assign last_port    = (32'(sample_s1.port) == NUM_PORTS - 1);
	assign idx          = IDX_W'(sample_s1.port);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_threshold    <= germ_pkg::TRIGGER_THRESHOLD_RESET;
			cfg_q.repeat_delay         <= germ_pkg::REPEAT_DELAY_RESET;
			cfg_q.stick_dpad_enable    <= 1'b0;
			cfg_q.stick_dpad_threshold <= germ_pkg::STICK_DPAD_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				germ_pkg::CFG_TRIGGER_THRESHOLD:    cfg_q.trigger_threshold <= cfg_data[7:0];
				germ_pkg::CFG_REPEAT_DELAY:         cfg_q.repeat_delay <= cfg_data;
				germ_pkg::CFG_STICK_DPAD_ENABLE:    cfg_q.stick_dpad_enable <= cfg_data[0];
				germ_pkg::CFG_STICK_DPAD_THRESHOLD: cfg_q.stick_dpad_threshold <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample_ready) begin
			s1_valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	germ_update u_update (
		.cfg       (cfg_q),
		.smp       (sample_s1),
		.last_port (last_port),
		.ps_cur    (ps_q[idx]),
		.acc_cur   (merge_q),
		.ps_next   (ps_next),
		.acc_next  (acc_next),
		.port_res  (port_res),
		.merge_res (merge_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				ps_q[i] <= '0;
			end
			merge_q <= '0;
		end else if (fire && in_range) begin
			ps_q[idx] <= ps_next;
			merge_q   <= acc_next;
		end
	end

	// A waiting merged word always goes out before a new sample is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (fire && in_range) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= last_port;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (fire && in_range) begin
				out_q  <= port_res;
				pend_q <= merge_res;
			end
		end
	end

`ifndef SYNTHESIS
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("merged word waiting with an empty output register");

	a_not_last_has_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> pend_valid_q)
		else $error("port word without last but no merged word behind it");

	a_merge_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind == germ_pkg::KIND_MERGED) |-> result.last)
		else $error("merged word without last");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !fire) |=> (s1_valid_q && $stable(sample_s1)))
		else $error("registered sample lost before processing");
`endif

endmodule

// File: sv/germ_update.sv
// ----------------------------------------------------------------------------
// germ_update
// Next-state and result logic for one controller sample: button mapping,
// edges, autorepeat, stick directions, link buttons and the frame merge.
// ----------------------------------------------------------------------------
module germ_update (
	input  germ_pkg::cfg_t        cfg,
	input  germ_pkg::sample_t     smp,
	input  logic                  last_port,
	input  germ_pkg::port_state_t ps_cur,
	input  germ_pkg::merge_t      acc_cur,
	output germ_pkg::port_state_t ps_next,
	output germ_pkg::merge_t      acc_next,
	output germ_pkg::result_t     port_res,
	output germ_pkg::result_t     merge_res
);

	function automatic logic [7:0] mag8(input logic [7:0] v);
		mag8 = v[7] ? 8'(~v + 8'd1) : v;
	endfunction

	germ_pkg::merge_t acc_base;
	logic             stand_in;
	logic             pad_used;
	logic [15:0]      b;
	logic [7:0]       ox_mag;
	logic [7:0]       oy_mag;
	logic             ox_zero;
	logic             oy_zero;
	logic [3:0]       dirs;
	logic [15:0]      pressed;
	logic [15:0]      released;
	logic [15:0]      rep;
	logic [3:0]       dnew;
	logic [15:0]      cnt_inc;
	logic [15:0]      cnt;
	logic [15:0]      link_new;
	logic [15:0]      link_press;

	assign stand_in = smp.link_connected && (smp.link_mode == germ_pkg::LINK_MODE_PAD);
	assign pad_used = (smp.err == germ_pkg::ERR_NONE) || stand_in;
	assign ox_mag   = mag8(ps_cur.stick_x);
	assign oy_mag   = mag8(ps_cur.stick_y);
	assign ox_zero  = (ps_cur.stick_x == 8'sd0);
	assign oy_zero  = (ps_cur.stick_y == 8'sd0);
	assign cnt_inc  = ps_cur.repeat_count + 16'd1;
	assign link_new   = smp.link_connected ? smp.link_buttons : ps_cur.link_buttons;
	assign link_press = link_new & ~ps_cur.link_buttons;

	// The frame merge restarts with the sample of port 0.
	assign acc_base = (smp.port == 2'd0) ? '0 : acc_cur;

	always_comb begin
		b = '0;
		dirs = ps_cur.dirs;
		if (pad_used) begin
			b = stand_in ? smp.link_buttons : smp.pad_buttons;
			if (smp.trigger_left >= cfg.trigger_threshold) b = b | germ_pkg::BTN_L;
			if (smp.trigger_right >= cfg.trigger_threshold) b = b | germ_pkg::BTN_R;
			// The d-pad mapping looks at the stick stored by the previous sample.
			if (cfg.stick_dpad_enable && (ox_mag >= cfg.stick_dpad_threshold ||
					oy_mag >= cfg.stick_dpad_threshold)) begin
				b = b & germ_pkg::DIR_CLEAR;
				if (!ps_cur.stick_x[7] && ox_mag >= cfg.stick_dpad_threshold)
					b = b | germ_pkg::BTN_RIGHT;
				if ((ps_cur.stick_x[7] || ox_zero) && ox_mag >= cfg.stick_dpad_threshold)
					b = b | germ_pkg::BTN_LEFT;
				if (!ps_cur.stick_y[7] && oy_mag >= cfg.stick_dpad_threshold)
					b = b | germ_pkg::BTN_UP;
				if ((ps_cur.stick_y[7] || oy_zero) && oy_mag >= cfg.stick_dpad_threshold)
					b = b | germ_pkg::BTN_DOWN;
			end
			dirs = '0;
			if (smp.stick_x[7]) dirs = dirs | germ_pkg::DIR_LEFT;
			if (!smp.stick_x[7] && smp.stick_x != 8'sd0) dirs = dirs | germ_pkg::DIR_RIGHT;
			if (smp.stick_y[7]) dirs = dirs | germ_pkg::DIR_DOWN;
			if (!smp.stick_y[7] && smp.stick_y != 8'sd0) dirs = dirs | germ_pkg::DIR_UP;
		end
	end

	always_comb begin
		pressed  = b & ~ps_cur.buttons;
		released = ps_cur.buttons & ~b;
		dnew     = dirs & ~ps_cur.dirs;
		rep      = ps_cur.buttons & b & germ_pkg::REPEAT_MASK;
		cnt      = '0;
		if (rep != 16'd0) begin
			cnt = cnt_inc;
			if (cnt_inc < cfg.repeat_delay || cnt_inc[0]) rep = '0;
		end
		rep = rep | pressed;
	end

	always_comb begin
		ps_next  = ps_cur;
		acc_next = acc_base;
		if (smp.err != germ_pkg::ERR_NOT_READY) begin
			ps_next.buttons       = b;
			ps_next.stick_x       = pad_used ? smp.stick_x : 8'sd0;
			ps_next.stick_y       = pad_used ? smp.stick_y : 8'sd0;
			ps_next.dirs          = dirs;
			ps_next.repeat_count  = cnt;
			ps_next.last_pressed  = pressed;
			ps_next.last_released = released;
			ps_next.last_repeat   = rep;
			ps_next.last_dirs_new = dnew;

			acc_next.held        = acc_base.held | b;
			acc_next.pressed     = acc_base.pressed | pressed;
			acc_next.released    = acc_base.released | released;
			acc_next.repeat_bits = acc_base.repeat_bits | rep;
			acc_next.dirs        = acc_base.dirs | dirs;
			acc_next.dirs_new    = acc_base.dirs_new | dnew;
			if (mag8(acc_base.stick_x) < mag8(ps_next.stick_x))
				acc_next.stick_x = ps_next.stick_x;
			if (mag8(acc_base.stick_y) < mag8(ps_next.stick_y))
				acc_next.stick_y = ps_next.stick_y;
		end
		ps_next.link_buttons  = link_new;
		acc_next.link_held    = acc_base.link_held | link_new;
		acc_next.link_pressed = acc_base.link_pressed | link_press;
	end

	always_comb begin
		port_res.result_kind      = germ_pkg::KIND_PORT;
		port_res.last             = !last_port;
		port_res.buttons_held     = ps_next.buttons;
		port_res.buttons_pressed  = ps_next.last_pressed;
		port_res.buttons_released = ps_next.last_released;
		port_res.buttons_repeat   = ps_next.last_repeat;
		port_res.stick_dirs       = ps_next.dirs;
		port_res.stick_dirs_new   = ps_next.last_dirs_new;
		port_res.link_held        = ps_next.link_buttons;
		port_res.link_pressed     = link_press;
		port_res.stick_x_out      = ps_next.stick_x;
		port_res.stick_y_out      = ps_next.stick_y;

		merge_res.result_kind      = germ_pkg::KIND_MERGED;
		merge_res.last             = 1'b1;
		merge_res.buttons_held     = acc_next.held;
		merge_res.buttons_pressed  = acc_next.pressed;
		merge_res.buttons_released = acc_next.released;
		merge_res.buttons_repeat   = acc_next.repeat_bits;
		merge_res.stick_dirs       = acc_next.dirs;
		merge_res.stick_dirs_new   = acc_next.dirs_new;
		merge_res.link_held        = acc_next.link_held;
		merge_res.link_pressed     = acc_next.link_pressed;
		merge_res.stick_x_out      = acc_next.stick_x;
		merge_res.stick_y_out      = acc_next.stick_y;
	end

endmodule

// File: bench/gamepad_edge_repeat_merge_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_edge_repeat_merge_top_test
// Self-checking bench for the gamepad edge, autorepeat and frame merge block.
// A scoreboard class predicts every port word and frame word from the
// accepted samples and checks the block's words against them in order. The
// run covers directed corner cases and random frames under several register
// settings, with random idling on both channels and a final stretch without
// any idling.
// ----------------------------------------------------------------------------
class pad_scoreboard;
	localparam int PORTS = 4;

	germ_pkg::result_t     reports_due[$];
	germ_pkg::port_state_t ps[PORTS];
	germ_pkg::merge_t      mrg;
	germ_pkg::cfg_t        cfg;
	int                    failures;
	int                    port_seen;
	int                    merged_seen;

	function new();
		foreach (ps[i]) ps[i] = '0;
		mrg = '0;
		cfg.trigger_threshold = germ_pkg::TRIGGER_THRESHOLD_RESET;
		cfg.repeat_delay = germ_pkg::REPEAT_DELAY_RESET;
		cfg.stick_dpad_enable = 1'b0;
		cfg.stick_dpad_threshold = germ_pkg::STICK_DPAD_THRESHOLD_RESET;
		failures = 0;
		port_seen = 0;
		merged_seen = 0;
	endfunction

	function int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	function int pending();
		return reports_due.size();
	endfunction

	function void set_register(logic [1:0] idx, logic [15:0] data);
		case (idx)
			germ_pkg::CFG_TRIGGER_THRESHOLD: cfg.trigger_threshold = data[7:0];
			germ_pkg::CFG_REPEAT_DELAY: cfg.repeat_delay = data;
			germ_pkg::CFG_STICK_DPAD_ENABLE: cfg.stick_dpad_enable = data[0];
			default: cfg.stick_dpad_threshold = data[7:0];
		endcase
	endfunction

	// Updates one port from an accepted sample and queues the words it causes.
	function void track_sample(germ_pkg::sample_t s);
		int                p, th, ox, oy;
		logic              stand_in;
		logic [15:0]       prev, b, pressed, released, rep, cnt, lprev, lpress;
		logic [3:0]        dprev, d, dnew;
		germ_pkg::result_t r;
		p = s.port;
		stand_in = s.link_connected && (s.link_mode == germ_pkg::LINK_MODE_PAD);
		if (p == 0)
			mrg = '0;
		if (s.err != germ_pkg::ERR_NOT_READY) begin
			prev = ps[p].buttons;
			dprev = ps[p].dirs;
			cnt = ps[p].repeat_count;
			if (s.err == germ_pkg::ERR_NONE || stand_in) begin
				// The d-pad mapping looks at the stick stored by the previous sample.
				th = cfg.stick_dpad_threshold;
				ox = $signed(ps[p].stick_x);
				oy = $signed(ps[p].stick_y);
				b = stand_in ? s.link_buttons : s.pad_buttons;
				if (s.trigger_left >= cfg.trigger_threshold)
					b |= germ_pkg::BTN_L;
				if (s.trigger_right >= cfg.trigger_threshold)
					b |= germ_pkg::BTN_R;
				if (cfg.stick_dpad_enable && (iabs(ox) >= th || iabs(oy) >= th)) begin
					b &= germ_pkg::DIR_CLEAR;
					if (ox >= th)
						b |= germ_pkg::BTN_RIGHT;
					if (ox <= -th)
						b |= germ_pkg::BTN_LEFT;
					if (oy >= th)
						b |= germ_pkg::BTN_UP;
					if (oy <= -th)
						b |= germ_pkg::BTN_DOWN;
				end
				ps[p].stick_x = s.stick_x;
				ps[p].stick_y = s.stick_y;
				d = '0;
				if ($signed(s.stick_x) < 0)
					d |= germ_pkg::DIR_LEFT;
				if ($signed(s.stick_x) > 0)
					d |= germ_pkg::DIR_RIGHT;
				if ($signed(s.stick_y) < 0)
					d |= germ_pkg::DIR_DOWN;
				if ($signed(s.stick_y) > 0)
					d |= germ_pkg::DIR_UP;
				ps[p].dirs = d;
			end else begin
				// Missing pad: buttons and stick drop to zero, direction bits stay.
				b = '0;
				ps[p].stick_x = '0;
				ps[p].stick_y = '0;
			end
			ps[p].buttons = b;
			d = ps[p].dirs;
			pressed = b & ~prev;
			released = prev & ~b;
			dnew = d & ~dprev;
			rep = prev & b & germ_pkg::REPEAT_MASK;
			if (rep != '0) begin
				cnt = cnt + 16'd1;
				if (cnt < cfg.repeat_delay || cnt[0])
					rep = '0;
			end else begin
				cnt = '0;
			end
			ps[p].repeat_count = cnt;
			rep |= pressed;
			ps[p].last_pressed = pressed;
			ps[p].last_released = released;
			ps[p].last_repeat = rep;
			ps[p].last_dirs_new = dnew;
			mrg.held |= b;
			mrg.pressed |= pressed;
			mrg.released |= released;
			mrg.repeat_bits |= rep;
			mrg.dirs |= d;
			mrg.dirs_new |= dnew;
			if (iabs($signed(mrg.stick_x)) < iabs($signed(ps[p].stick_x)))
				mrg.stick_x = ps[p].stick_x;
			if (iabs($signed(mrg.stick_y)) < iabs($signed(ps[p].stick_y)))
				mrg.stick_y = ps[p].stick_y;
		end
		lprev = ps[p].link_buttons;
		if (s.link_connected)
			ps[p].link_buttons = s.link_buttons;
		lpress = ps[p].link_buttons & ~lprev;
		mrg.link_held |= ps[p].link_buttons;
		mrg.link_pressed |= lpress;

		r.result_kind = germ_pkg::KIND_PORT;
		r.last = (p != PORTS - 1);
		r.buttons_held = ps[p].buttons;
		r.buttons_pressed = ps[p].last_pressed;
		r.buttons_released = ps[p].last_released;
		r.buttons_repeat = ps[p].last_repeat;
		r.stick_dirs = ps[p].dirs;
		r.stick_dirs_new = ps[p].last_dirs_new;
		r.link_held = ps[p].link_buttons;
		r.link_pressed = lpress;
		r.stick_x_out = ps[p].stick_x;
		r.stick_y_out = ps[p].stick_y;
		reports_due.push_back(r);
		if (p == PORTS - 1) begin
			r.result_kind = germ_pkg::KIND_MERGED;
			r.last = 1'b1;
			r.buttons_held = mrg.held;
			r.buttons_pressed = mrg.pressed;
			r.buttons_released = mrg.released;
			r.buttons_repeat = mrg.repeat_bits;
			r.stick_dirs = mrg.dirs;
			r.stick_dirs_new = mrg.dirs_new;
			r.link_held = mrg.link_held;
			r.link_pressed = mrg.link_pressed;
			r.stick_x_out = mrg.stick_x;
			r.stick_y_out = mrg.stick_y;
			reports_due.push_back(r);
		end
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(germ_pkg::result_t got);
		germ_pkg::result_t want;
		if (reports_due.size() == 0) begin
			$error("result word 0x%0h arrived with nothing expected", got);
			failures++;
			return;
		end
		want = reports_due.pop_front();
		if (want.result_kind == germ_pkg::KIND_MERGED)
			merged_seen++;
		else
			port_seen++;
		compare_field("result_kind", want.result_kind, got.result_kind);
		compare_field("last", want.last, got.last);
		compare_field("buttons_held", want.buttons_held, got.buttons_held);
		compare_field("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
		compare_field("buttons_released", want.buttons_released, got.buttons_released);
		compare_field("buttons_repeat", want.buttons_repeat, got.buttons_repeat);
		compare_field("stick_dirs", want.stick_dirs, got.stick_dirs);
		compare_field("stick_dirs_new", want.stick_dirs_new, got.stick_dirs_new);
		compare_field("link_held", want.link_held, got.link_held);
		compare_field("link_pressed", want.link_pressed, got.link_pressed);
		compare_field("stick_x_out", $unsigned(want.stick_x_out), $unsigned(got.stick_x_out));
		compare_field("stick_y_out", $unsigned(want.stick_y_out), $unsigned(got.stick_y_out));
	endfunction
endclass

module gamepad_edge_repeat_merge_top_test;
	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	germ_pkg::sample_t sample;
	logic              result_valid;
	logic              result_ready;
	germ_pkg::result_t result;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;

	pad_scoreboard sb = new();

	int          send_gap_pct;
	int          stall_pct;
	int          samples_sent;
	int          settings_used;
	logic [15:0] pad_hold[4];
	logic [15:0] link_hold[4];

	gamepad_edge_repeat_merge_top #(.NUM_PORTS(4)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(5ms);
		$error("timed out with %0d words still expected", sb.pending());
		$display("gamepad_edge_repeat_merge_top test failed");
		$finish;
	end

	// Result side: takes words with random stall bursts.
	initial begin : result_sink
		int hold;
		hold = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				sb.check_result(result);
			if (hold > 0) begin
				hold--;
				result_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(0, 14);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic germ_pkg::sample_t make_sample(logic [1:0] port, logic [1:0] err,
			logic [15:0] pad, logic [7:0] tl, logic [7:0] tr, logic [7:0] sx,
			logic [7:0] sy, logic lc, logic [1:0] lm, logic [15:0] lb);
		germ_pkg::sample_t s;
		s.port = port;
		s.err = err;
		s.pad_buttons = pad;
		s.trigger_left = tl;
		s.trigger_right = tr;
		s.stick_x = sx;
		s.stick_y = sy;
		s.link_connected = lc;
		s.link_mode = lm;
		s.link_buttons = lb;
		return s;
	endfunction

	function automatic logic [7:0] random_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return sb.cfg.trigger_threshold;
			3: return sb.cfg.trigger_threshold - 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// Stick values favor the rails, the center and the d-pad threshold.
	function automatic logic [7:0] random_axis();
		int th;
		th = sb.cfg.stick_dpad_threshold;
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'(th);
			4: return 8'(-th);
			5: return 8'($urandom_range(0, 6) - 3);
			default: return 8'($urandom);
		endcase
	endfunction

	// Buttons are sticky per port so that holds last long enough to repeat.
	function automatic germ_pkg::sample_t random_sample(logic [1:0] port);
		germ_pkg::sample_t s;
		int                k;
		k = $urandom_range(0, 99);
		if (k < 78)
			s.err = germ_pkg::ERR_NONE;
		else if (k < 86)
			s.err = germ_pkg::ERR_NOT_READY;
		else if (k < 93)
			s.err = germ_pkg::ERR_NO_PAD;
		else
			s.err = germ_pkg::ERR_XFER;
		if ($urandom_range(0, 7) == 0)
			pad_hold[port] ^= 16'($urandom) & 16'($urandom);
		if ($urandom_range(0, 31) == 0)
			pad_hold[port] = 16'($urandom);
		if ($urandom_range(0, 7) == 0)
			link_hold[port] ^= 16'($urandom) & 16'($urandom);
		if ($urandom_range(0, 31) == 0)
			link_hold[port] = 16'($urandom);
		s.port = port;
		s.pad_buttons = pad_hold[port];
		s.trigger_left = random_level();
		s.trigger_right = random_level();
		s.stick_x = random_axis();
		s.stick_y = random_axis();
		s.link_connected = 1'($urandom_range(0, 1));
		s.link_mode = 2'($urandom_range(0, 3));
		s.link_buttons = link_hold[port];
		return s;
	endfunction

	task automatic send_sample(germ_pkg::sample_t s);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < send_gap_pct)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		sb.track_sample(s);
		samples_sent++;
	endtask

	// Holds the sender off until every expected word is in, then lets the
	// pipeline settle.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic apply_config(logic [7:0] tt, logic [15:0] rd, logic en, logic [7:0] th);
		write_register(germ_pkg::CFG_TRIGGER_THRESHOLD, {8'd0, tt});
		write_register(germ_pkg::CFG_REPEAT_DELAY, rd);
		write_register(germ_pkg::CFG_STICK_DPAD_ENABLE, {15'd0, en});
		write_register(germ_pkg::CFG_STICK_DPAD_THRESHOLD, {8'd0, th});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly whole frames in port order; the rest are stray or cut-short frames.
	task automatic run_frames(int count);
		int sent, k, n;
		sent = 0;
		while (sent < count) begin
			k = $urandom_range(0, 99);
			if (k < 85) begin
				for (int p = 0; p < 4; p++)
					send_sample(random_sample(2'(p)));
				sent += 4;
			end else if (k < 93) begin
				n = $urandom_range(1, 3);
				for (int p = 0; p < n; p++)
					send_sample(random_sample(2'(p)));
				sent += n;
			end else begin
				send_sample(random_sample(2'($urandom_range(0, 3))));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= germ_pkg::CFG_TRIGGER_THRESHOLD;
		cfg_data <= '0;
		send_gap_pct = 15;
		stall_pct = 15;
		samples_sent = 0;
		settings_used = 1;
		foreach (pad_hold[i]) begin
			pad_hold[i] = 16'($urandom);
			link_hold[i] = 16'($urandom);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes, trigger threshold edges, link stand-in,
		// missing pad, not-ready port and link absent.
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'hFFFF, 8'd255, 8'd0,
			8'h7F, 8'h80, 1'b1, 2'd1, 16'hFFFF));
		send_sample(make_sample(2'd1, germ_pkg::ERR_NONE, 16'h0000, 8'd100, 8'd99,
			8'h80, 8'h7F, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd2, germ_pkg::ERR_NO_PAD, 16'h1234, 8'd0, 8'd0,
			8'h05, 8'hFB, 1'b1, germ_pkg::LINK_MODE_PAD, 16'hA5A5));
		send_sample(make_sample(2'd3, germ_pkg::ERR_XFER, 16'hFFFF, 8'd255, 8'd255,
			8'h01, 8'h01, 1'b0, germ_pkg::LINK_MODE_PAD, 16'hFFFF));
		send_sample(make_sample(2'd0, germ_pkg::ERR_NOT_READY, 16'h0000, 8'd0,
			8'd0, 8'h00, 8'h00, 1'b1, 2'd2, 16'h5A5A));
		send_sample(make_sample(2'd1, germ_pkg::ERR_NONE, 16'h0000, 8'd100, 8'd255,
			8'hFF, 8'h00, 1'b1, 2'd3, 16'h0000));
		send_sample(make_sample(2'd2, germ_pkg::ERR_XFER, 16'hFFFF, 8'd255, 8'd255,
			8'h7F, 8'h7F, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd3, germ_pkg::ERR_NONE, 16'h000F, 8'd99, 8'd100,
			8'h00, 8'h00, 1'b1, germ_pkg::LINK_MODE_PAD, 16'h8001));
		// Ports out of order: the merge still clears on port 0 and closes on port 3.
		send_sample(make_sample(2'd3, germ_pkg::ERR_NONE, 16'h0F00, 8'd0, 8'd0,
			8'h10, 8'hF0, 1'b1, 2'd1, 16'h0001));
		send_sample(make_sample(2'd1, germ_pkg::ERR_NONE, 16'h0F00, 8'd0, 8'd0,
			8'hF0, 8'h10, 1'b1, 2'd1, 16'h0003));
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'h3000, 8'd200, 8'd0,
			8'h00, 8'h00, 1'b0, 2'd1, 16'h0000));
		send_sample(make_sample(2'd2, germ_pkg::ERR_NONE, 16'hC000, 8'd0, 8'd200,
			8'h40, 8'hC0, 1'b1, 2'd2, 16'hFF00));
		wait_drained();

		// Stick d-pad with a zero threshold: a centered stick sets both
		// opposite directions, and mapping uses the previously stored stick.
		apply_config(8'd0, 16'd0, 1'b1, 8'd0);
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'h0000, 8'd0, 8'd0,
			8'h00, 8'h00, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'h00F0, 8'd0, 8'd0,
			8'h80, 8'h7F, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'h0000, 8'd0, 8'd0,
			8'h00, 8'h00, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd0, germ_pkg::ERR_NONE, 16'h000F, 8'd0, 8'd0,
			8'h00, 8'h00, 1'b1, germ_pkg::LINK_MODE_PAD, 16'h0000));
		wait_drained();

		// D-pad threshold of 128: only a full negative deflection reaches it.
		apply_config(8'd255, 16'hFFFF, 1'b1, 8'd128);
		send_sample(make_sample(2'd1, germ_pkg::ERR_NONE, 16'h0000, 8'd254, 8'd255,
			8'h80, 8'h7F, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd1, germ_pkg::ERR_NONE, 16'h000F, 8'd255, 8'd254,
			8'h00, 8'h00, 1'b0, germ_pkg::LINK_MODE_PAD, 16'h0000));
		send_sample(make_sample(2'd3, germ_pkg::ERR_NONE, 16'h0000, 8'd0, 8'd0,
			8'h80, 8'h80, 1'b1, 2'd3, 16'hFFFF));
		wait_drained();

		apply_config(germ_pkg::TRIGGER_THRESHOLD_RESET, germ_pkg::REPEAT_DELAY_RESET, 1'b0,
			germ_pkg::STICK_DPAD_THRESHOLD_RESET);
		send_gap_pct = 20;
		stall_pct = 20;
		run_frames(150);
		wait_drained();

		apply_config(8'd0, 16'd0, 1'b1, 8'd0);
		send_gap_pct = 0;
		stall_pct = 30;
		run_frames(150);
		wait_drained();

		apply_config(8'd255, 16'hFFFF, 1'b0, 8'd128);
		send_gap_pct = 30;
		stall_pct = 0;
		run_frames(150);
		wait_drained();

		apply_config(8'($urandom), 16'($urandom_range(1, 24)), 1'b1,
			8'($urandom_range(1, 127)));
		send_gap_pct = 10;
		stall_pct = 10;
		run_frames(150);
		wait_drained();

		// Final stretch with no idling on either side.
		apply_config(8'd128, 16'd3, 1'b1, 8'd128);
		send_gap_pct = 0;
		stall_pct = 0;
		run_frames(150);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Checked %0d port words and %0d frame words from %0d samples",
			sb.port_seen, sb.merged_seen, samples_sent);
		$display("under %0d register settings, with out-of-order ports and stalls on both sides.",
			settings_used);
		if (sb.failures == 0)
			$display("gamepad_edge_repeat_merge_top test passed");
		else
			$display("gamepad_edge_repeat_merge_top test failed");
		$finish;
	end
endmodule

// File: sim.f
sv/germ_pkg.sv
sv/germ_update.sv
sv/gamepad_edge_repeat_merge_top.sv
bench/gamepad_edge_repeat_merge_top_test.sv
